>>> src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic concurrent assertion on a given clock and active-low reset.
`define BTS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same, on the block's own clock and reset.
`define BTS_ASSERT_CLK(name, prop) `BTS_ASSERT(name, clk_i, rst_ni, prop)

`endif

>>> src/bts_pkg.sv
// Package: shared types, codes and constants of the brake and turn signal controller.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Item kinds
  localparam logic [1:0] KIND_SPEED = 2'd0;
  localparam logic [1:0] KIND_VOICE = 2'd1;
  localparam logic [1:0] KIND_EVAL  = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;  // reserved, changes nothing

  // Voice recognizer codes
  localparam logic [7:0] VOICE_LEFT  = 8'd16;
  localparam logic [7:0] VOICE_RIGHT = 8'd17;
  localparam logic [7:0] VOICE_BRAKE = 8'd18;

  localparam logic [11:0] SPEED_MAX = 12'd3000;

  // Register indexes
  localparam logic [2:0] CFG_BRAKE_TH      = 3'd0;
  localparam logic [2:0] CFG_HARD_BRAKE_TH = 3'd1;
  localparam logic [2:0] CFG_TURN_TH       = 3'd2;
  localparam logic [2:0] CFG_RELEASE_TH    = 3'd3;
  localparam logic [2:0] CFG_BRAKE_HOLD    = 3'd4;
  localparam logic [2:0] CFG_VOICE_TIMEOUT = 3'd5;

  // Register reset values
  localparam logic signed [15:0] BRAKE_TH_RST      = -16'sd700;
  localparam logic signed [15:0] HARD_BRAKE_TH_RST = -16'sd8000;
  localparam logic [14:0]        TURN_TH_RST       = 15'd1400;
  localparam logic [14:0]        RELEASE_TH_RST    = 15'd100;
  localparam logic [15:0]        BRAKE_HOLD_RST    = 16'd3000;
  localparam logic [15:0]        VOICE_TIMEOUT_RST = 16'd10000;

  typedef enum logic [1:0] {
    SIG_IDLE  = 2'd0,
    SIG_BRAKE = 2'd1,
    SIG_LEFT  = 2'd2,
    SIG_RIGHT = 2'd3
  } signal_e;

  typedef struct packed {
    logic signed [15:0] brake_th;
    logic signed [15:0] hard_brake_th;
    logic [14:0]        turn_th;
    logic [14:0]        release_th;
    logic [15:0]        brake_hold;
    logic [15:0]        voice_timeout;
  } bts_cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        speed;
    logic [7:0]         voice;
    logic signed [15:0] roll;
    logic [31:0]        now;
  } bts_item_t;

endpackage

>>> src/bts_cfg_regs.sv
// APB register file holding the thresholds and timing limits.
`timescale 1ns / 1ps

module bts_cfg_regs
  import bts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output bts_cfg_t          cfg_o
);

  bts_cfg_t   cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_th      <= BRAKE_TH_RST;
      cfg_q.hard_brake_th <= HARD_BRAKE_TH_RST;
      cfg_q.turn_th       <= TURN_TH_RST;
      cfg_q.release_th    <= RELEASE_TH_RST;
      cfg_q.brake_hold    <= BRAKE_HOLD_RST;
      cfg_q.voice_timeout <= VOICE_TIMEOUT_RST;
    end else if (wr_en) begin
      case (idx)
        CFG_BRAKE_TH:      cfg_q.brake_th      <= pwdata[15:0];
        CFG_HARD_BRAKE_TH: cfg_q.hard_brake_th <= pwdata[15:0];
        CFG_TURN_TH:       cfg_q.turn_th       <= pwdata[14:0];
        CFG_RELEASE_TH:    cfg_q.release_th    <= pwdata[14:0];
        CFG_BRAKE_HOLD:    cfg_q.brake_hold    <= pwdata[15:0];
        CFG_VOICE_TIMEOUT: cfg_q.voice_timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_BRAKE_TH:      prdata = {16'd0, cfg_q.brake_th};
      CFG_HARD_BRAKE_TH: prdata = {16'd0, cfg_q.hard_brake_th};
      CFG_TURN_TH:       prdata = {17'd0, cfg_q.turn_th};
      CFG_RELEASE_TH:    prdata = {17'd0, cfg_q.release_th};
      CFG_BRAKE_HOLD:    prdata = {16'd0, cfg_q.brake_hold};
      CFG_VOICE_TIMEOUT: prdata = {16'd0, cfg_q.voice_timeout};
      default:           prdata = '0;
    endcase
  end

endmodule

>>> src/bts_core.sv
// Controller state: speed history, voice request, turn lock, timer and the signal state machine.
`timescale 1ns / 1ps

module bts_core
  import bts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bts_item_t          item_i,
  input  bts_cfg_t           cfg_i,
  output signal_e            mode_d_o,
  output logic signed [15:0] diff_d_o
);

  // Speed history as a shift line, newest sample in tap 0.
  logic [11:0]        ring_q [4];
  signal_e            mode_q, mode_d;
  signal_e            voice_q, voice_d;
  logic               lock_q, lock_d;
  logic [31:0]        trig_q, trig_d;
  logic signed [15:0] diff_q, diff_d;

  logic [11:0]        speed_sat;
  logic signed [17:0] d_full;
  logic signed [15:0] d;
  logic signed [16:0] roll_x, turn_x, rel_x;
  logic [31:0]        elapsed;
  logic               is_eval;
  logic               d_brake, d_hard, roll_left, roll_right;
  logic               lt_hold, gt_hold, lt_to, gt_to;
  logic               lean, released, vmatch, lock_eff, wait_voice, turn_clear, extend;

  assign speed_sat = (item_i.speed > SPEED_MAX) ? SPEED_MAX : item_i.speed;

  // d = 10*cur - (r1 + 4*r2 + 5*r3)
  assign d_full = $signed({6'd0, ring_q[0]}) * 18'sd10
                - ($signed({6'd0, ring_q[1]})
                 + $signed({6'd0, ring_q[2]}) * 18'sd4
                 + $signed({6'd0, ring_q[3]}) * 18'sd5);
  assign d = d_full[15:0];

  assign roll_x = {item_i.roll[15], item_i.roll};
  assign turn_x = $signed({2'b00, cfg_i.turn_th});
  assign rel_x  = $signed({2'b00, cfg_i.release_th});

  assign is_eval    = step_i && (item_i.kind == KIND_EVAL);
  assign d_brake    = d < cfg_i.brake_th;
  assign d_hard     = d < cfg_i.hard_brake_th;
  assign roll_left  = roll_x > turn_x;
  assign roll_right = roll_x < -turn_x;

  // Timer differences wrap modulo 2^32.
  assign elapsed = item_i.now - trig_q;
  assign lt_hold = elapsed < {16'd0, cfg_i.brake_hold};
  assign gt_hold = elapsed > {16'd0, cfg_i.brake_hold};
  assign lt_to   = elapsed < {16'd0, cfg_i.voice_timeout};
  assign gt_to   = elapsed > {16'd0, cfg_i.voice_timeout};

  // Turn rules, direction taken from the current mode.
  assign lean     = (mode_q == SIG_LEFT) ? roll_left : roll_right;
  assign released = (mode_q == SIG_LEFT) ? (roll_x < rel_x) : (roll_x > -rel_x);
  assign vmatch   = voice_q == mode_q;
  assign lock_eff = lock_q | lean;
  // Unlocked voice turn still inside its timeout: no release, only braking ends it.
  assign wait_voice = vmatch && !lock_eff && lt_to;
  assign turn_clear = (vmatch && !lock_eff && gt_to) || (released && !wait_voice);
  assign extend     = gt_hold && ((voice_q == SIG_BRAKE) || d_hard);

  // Next signal state
  always_comb begin
    mode_d = mode_q;
    if (is_eval) begin
      case (mode_q)
        SIG_IDLE: begin
          if (d_brake || voice_q == SIG_BRAKE) mode_d = SIG_BRAKE;
          else if (roll_left || voice_q == SIG_LEFT) mode_d = SIG_LEFT;
          else if (roll_right || voice_q == SIG_RIGHT) mode_d = SIG_RIGHT;
        end
        SIG_BRAKE: begin
          if (!lt_hold && !extend) begin
            if (roll_right) mode_d = SIG_RIGHT;
            else if (roll_left) mode_d = SIG_LEFT;
            else mode_d = SIG_IDLE;
          end
        end
        default: begin
          if (d_brake) mode_d = SIG_BRAKE;
          else if (turn_clear) mode_d = SIG_IDLE;
        end
      endcase
    end
  end

  // Voice request, lock, trigger time and last difference
  always_comb begin
    voice_d = voice_q;
    lock_d  = lock_q;
    trig_d  = trig_q;
    diff_d  = diff_q;
    if (step_i && item_i.kind == KIND_VOICE) begin
      case (item_i.voice)
        VOICE_BRAKE: voice_d = SIG_BRAKE;
        VOICE_LEFT:  voice_d = SIG_LEFT;
        VOICE_RIGHT: voice_d = SIG_RIGHT;
        default: ;
      endcase
    end
    if (is_eval) begin
      diff_d = d;
      case (mode_q)
        SIG_IDLE: begin
          if (d_brake || voice_q == SIG_BRAKE) begin
            voice_d = SIG_IDLE;
            trig_d  = item_i.now;
          end else if (roll_left || voice_q == SIG_LEFT ||
                       roll_right || voice_q == SIG_RIGHT) begin
            trig_d = item_i.now;
          end
        end
        SIG_BRAKE: begin
          if (extend) begin
            voice_d = SIG_IDLE;
            trig_d  = item_i.now;
          end
        end
        default: begin
          if (d_brake || turn_clear) begin
            voice_d = SIG_IDLE;
            lock_d  = 1'b0;
          end else begin
            lock_d = lock_eff;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q  <= '{default: '0};
      mode_q  <= SIG_IDLE;
      voice_q <= SIG_IDLE;
      lock_q  <= 1'b0;
      trig_q  <= '0;
      diff_q  <= '0;
    end else begin
      if (step_i && item_i.kind == KIND_SPEED) begin
        ring_q[0] <= speed_sat;
        ring_q[1] <= ring_q[0];
        ring_q[2] <= ring_q[1];
        ring_q[3] <= ring_q[2];
      end
      mode_q  <= mode_d;
      voice_q <= voice_d;
      lock_q  <= lock_d;
      trig_q  <= trig_d;
      diff_q  <= diff_d;
    end
  end

  assign mode_d_o = mode_d;
  assign diff_d_o = diff_d;

endmodule

>>> src/brake_turn_signal_controller.sv
// Top level of the brake and turn signal controller.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o): one item per transfer. kind_i
//   picks a speed sample, a voice command or an evaluation; the other fields
//   are read as that kind needs them.
//   Output channel (out_valid_o / out_stall_i): exactly one result per input
//   item, in order: the signal state after the item and the last evaluated
//   weighted speed difference.
//   APB port: six registers at byte addresses 0, 4, ..., 20. The user writes
//   them only while no item is in flight; the block does not enforce it.
//   pready is tied high, reads return the value.
// Timing
//   Each item passes through the input register, then the state update loads
//   the result register once it is free or draining. Throughput is one item
//   per cycle while the receiver does not stall, set by the combinational
//   state update between the two registers.
// Stall
//   While the receiver stalls, the result register holds; one more item may
//   wait in the input register, after that in_stall_o rises.
// Reset
//   rst_ni low clears the speed history, state, timer and both valid flags,
//   and loads the register defaults. No clearing pass is needed.

module brake_turn_signal_controller
  import bts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [11:0]        speed_sample_i,
  input  logic [7:0]         voice_code_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic [31:0]        now_ms_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         signal_state_o,
  output logic signed [15:0] speed_difference_o
);

  bts_cfg_t           cfg;
  bts_item_t          item_q;
  logic               in_valid_q, in_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               in_xfer, advance;
  signal_e            mode_d;
  logic signed [15:0] diff_d;
  logic [1:0]         state_q;
  logic signed [15:0] diff_out_q;

  bts_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held item moves on whenever the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register, payload only
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.kind  <= kind_i;
      item_q.speed <= speed_sample_i;
      item_q.voice <= voice_code_i;
      item_q.roll  <= roll_angle_i;
      item_q.now   <= now_ms_i;
    end
  end

  bts_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .mode_d_o (mode_d),
    .diff_d_o (diff_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      state_q    <= mode_d;
      diff_out_q <= diff_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign signal_state_o     = state_q;
  assign speed_difference_o = diff_out_q;

endmodule

>>> src/bts_checker.sv
// Port-level checker for the brake and turn signal controller, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         signal_state_o,
  input logic signed [15:0] speed_difference_o
);

  // A stalled result holds.
  `BTS_ASSERT_CLK(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(signal_state_o) && $stable(speed_difference_o)))

  // An accepted item is followed by a valid result, its own or a stalled older one.
  `BTS_ASSERT_CLK(a_latency, (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)

  // Input backpressure only comes from a stalled result.
  `BTS_ASSERT_CLK(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))

endmodule

bind brake_turn_signal_controller bts_checker u_bts_checker (.*);

>>> test/bts_signal_checker.sv
// Checker for the brake and turn signal controller: predicts each result and compares it.
`timescale 1ns / 1ps

module bts_signal_checker
  import bts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [11:0]        speed_sample_i,
  input  logic [7:0]         voice_code_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic [31:0]        now_ms_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [1:0]         signal_state_o,
  input  logic signed [15:0] speed_difference_o,
  output int                 error_count,
  output int                 results_pending
);

  typedef struct packed {
    signal_e            state;
    logic signed [15:0] diff;
  } signal_result_t;

  // predictor state
  bts_cfg_t           cfg;
  logic [11:0]        speed_hist [4];
  logic [1:0]         hist_pos;
  signal_e            mode;
  signal_e            voice_req;
  logic               locked;
  logic [31:0]        trig_ms;
  logic signed [15:0] last_diff;

  signal_result_t pending_signals [$];

  function automatic void clear_controller();
    cfg.brake_th      = BRAKE_TH_RST;
    cfg.hard_brake_th = HARD_BRAKE_TH_RST;
    cfg.turn_th       = TURN_TH_RST;
    cfg.release_th    = RELEASE_TH_RST;
    cfg.brake_hold    = BRAKE_HOLD_RST;
    cfg.voice_timeout = VOICE_TIMEOUT_RST;
    for (int i = 0; i < 4; i++) speed_hist[i] = '0;
    hist_pos  = '0;
    mode      = SIG_IDLE;
    voice_req = SIG_IDLE;
    locked    = 1'b0;
    trig_ms   = '0;
    last_diff = '0;
  endfunction

  function automatic void write_setting(logic [2:0] idx, logic [31:0] data);
    case (idx)
      CFG_BRAKE_TH:      cfg.brake_th      = data[15:0];
      CFG_HARD_BRAKE_TH: cfg.hard_brake_th = data[15:0];
      CFG_TURN_TH:       cfg.turn_th       = data[14:0];
      CFG_RELEASE_TH:    cfg.release_th    = data[14:0];
      CFG_BRAKE_HOLD:    cfg.brake_hold    = data[15:0];
      CFG_VOICE_TIMEOUT: cfg.voice_timeout = data[15:0];
      default: ;
    endcase
  endfunction

  // turn states: brake overrides, lean locks, voice turns time out, roll releases
  function automatic void step_turn(int d, int roll, logic [31:0] now, signal_e dir);
    int          brake_lim;
    int          turn_lim;
    int          rel_lim;
    bit          lean;
    bit          released;
    logic [31:0] elapsed;
    brake_lim = int'($signed(cfg.brake_th));
    turn_lim  = int'(cfg.turn_th);
    rel_lim   = int'(cfg.release_th);
    if (d < brake_lim) begin
      voice_req = SIG_IDLE;
      locked    = 1'b0;
      mode      = SIG_BRAKE;
      return;
    end
    if (dir == SIG_LEFT) begin
      lean     = roll > turn_lim;
      released = roll < rel_lim;
    end else begin
      lean     = roll < -turn_lim;
      released = roll > -rel_lim;
    end
    if (lean) locked = 1'b1;
    elapsed = now - trig_ms;
    if (voice_req == dir && !locked) begin
      if (elapsed < {16'd0, cfg.voice_timeout}) return;
      if (elapsed > {16'd0, cfg.voice_timeout}) begin
        locked    = 1'b0;
        voice_req = SIG_IDLE;
        mode      = SIG_IDLE;
        return;
      end
    end
    if (released) begin
      locked    = 1'b0;
      voice_req = SIG_IDLE;
      mode      = SIG_IDLE;
    end
  endfunction

  function automatic void evaluate_signal(int roll, logic [31:0] now);
    logic [1:0]  p1;
    logic [1:0]  p2;
    logic [1:0]  p3;
    int          d;
    int          brake_lim;
    int          hard_lim;
    int          turn_lim;
    logic [31:0] elapsed;
    p1 = hist_pos - 2'd1;
    p2 = hist_pos - 2'd2;
    p3 = hist_pos - 2'd3;
    d  = 10 * int'(speed_hist[hist_pos])
         - (int'(speed_hist[p1]) + 4 * int'(speed_hist[p2]) + 5 * int'(speed_hist[p3]));
    last_diff = d[15:0];
    brake_lim = int'($signed(cfg.brake_th));
    hard_lim  = int'($signed(cfg.hard_brake_th));
    turn_lim  = int'(cfg.turn_th);
    case (mode)
      SIG_IDLE: begin
        if (d < brake_lim || voice_req == SIG_BRAKE) begin
          voice_req = SIG_IDLE;
          trig_ms   = now;
          mode      = SIG_BRAKE;
        end else if (roll > turn_lim || voice_req == SIG_LEFT) begin
          trig_ms = now;
          mode    = SIG_LEFT;
        end else if (roll < -turn_lim || voice_req == SIG_RIGHT) begin
          trig_ms = now;
          mode    = SIG_RIGHT;
        end
      end
      SIG_BRAKE: begin
        elapsed = now - trig_ms;
        if (elapsed < {16'd0, cfg.brake_hold}) begin
          // still holding
        end else if (elapsed > {16'd0, cfg.brake_hold} &&
                     (voice_req == SIG_BRAKE || d < hard_lim)) begin
          voice_req = SIG_IDLE;
          trig_ms   = now;
        end else if (roll < -turn_lim) begin
          mode = SIG_RIGHT;
        end else if (roll > turn_lim) begin
          mode = SIG_LEFT;
        end else begin
          mode = SIG_IDLE;
        end
      end
      SIG_LEFT: step_turn(d, roll, now, SIG_LEFT);
      default:  step_turn(d, roll, now, SIG_RIGHT);
    endcase
  endfunction

  function automatic signal_result_t predict_signal(logic [1:0] kind, logic [11:0] speed,
                                                    logic [7:0] voice, logic signed [15:0] roll,
                                                    logic [31:0] now);
    signal_result_t r;
    int             roll_v;
    roll_v = int'(roll);
    case (kind)
      KIND_SPEED: begin
        hist_pos             = hist_pos + 2'd1;
        speed_hist[hist_pos] = (speed > SPEED_MAX) ? SPEED_MAX : speed;
      end
      KIND_VOICE: begin
        if (voice == VOICE_BRAKE)      voice_req = SIG_BRAKE;
        else if (voice == VOICE_LEFT)  voice_req = SIG_LEFT;
        else if (voice == VOICE_RIGHT) voice_req = SIG_RIGHT;
      end
      KIND_EVAL: evaluate_signal(roll_v, now);
      default: ;
    endcase
    r.state = mode;
    r.diff  = last_diff;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    signal_result_t exp_r;
    if (!rst_ni) begin
      clear_controller();
      pending_signals.delete();
      error_count     = 0;
      results_pending = 0;
    end else begin
      if (psel && penable && pwrite && pready)
        write_setting(paddr[ADDR_W-1:2], pwdata);
      // results first: an item taken at this edge cannot have its result out yet
      if (out_valid_o && !out_stall_i) begin
        if (pending_signals.size() == 0) begin
          if (error_count < 10)
            $display("%0t: result with nothing pending: state %0d difference %0d",
                     $time, signal_state_o, speed_difference_o);
          error_count++;
        end else begin
          exp_r = pending_signals.pop_front();
          if (signal_state_o !== exp_r.state || speed_difference_o !== exp_r.diff) begin
            if (error_count < 10)
              $display("%0t: mismatch: state exp %0d got %0d, difference exp %0d got %0d",
                       $time, exp_r.state, signal_state_o, exp_r.diff, speed_difference_o);
            error_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        pending_signals.push_back(predict_signal(kind_i, speed_sample_i, voice_code_i,
                                                 roll_angle_i, now_ms_i));
      results_pending = pending_signals.size();
    end
  end

endmodule

>>> test/testbench.sv
// Top of the brake and turn signal controller testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module testbench;
  import bts_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         kind_i;
  logic [11:0]        speed_sample_i;
  logic [7:0]         voice_code_i;
  logic signed [15:0] roll_angle_i;
  logic [31:0]        now_ms_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         signal_state_o;
  logic signed [15:0] speed_difference_o;

  int error_count;
  int results_pending;
  int cycle_count = 0;

  // idling knobs, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // local copy of what was written, used only to aim the stimulus
  int          turn_cfg    = int'(TURN_TH_RST);
  int          release_cfg = int'(RELEASE_TH_RST);
  logic [31:0] hold_cfg    = 32'(BRAKE_HOLD_RST);
  logic [31:0] timeout_cfg = 32'(VOICE_TIMEOUT_RST);

  logic [31:0] clock_ms;    // running time stamp for evaluations
  int          last_speed;  // lets speed samples drift instead of jumping

  brake_turn_signal_controller u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .speed_sample_i     (speed_sample_i),
    .voice_code_i       (voice_code_i),
    .roll_angle_i       (roll_angle_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .signal_state_o     (signal_state_o),
    .speed_difference_o (speed_difference_o)
  );

  bts_signal_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .speed_sample_i     (speed_sample_i),
    .voice_code_i       (voice_code_i),
    .roll_angle_i       (roll_angle_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .signal_state_o     (signal_state_o),
    .speed_difference_o (speed_difference_o),
    .error_count        (error_count),
    .results_pending    (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver back-pressure, redrawn every falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One input transfer. Called at a falling edge; returns at the falling edge after
  // the transfer with valid still high, so back-to-back items need no extra edge.
  task automatic send_item(input logic [1:0] kind, input logic [11:0] speed,
                           input logic [7:0] voice, input logic signed [15:0] roll,
                           input logic [31:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    kind_i         = kind;
    speed_sample_i = speed;
    voice_code_i   = voice;
    roll_angle_i   = roll;
    now_ms_i       = now;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Sender goes quiet until every expected result is back, plus slack for the
  // two-stage pipe.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Rewrite all six registers; only done with the pipe empty.
  task automatic load_settings(input int brake, input int hard, input int turn,
                               input int rel, input int hold, input int tmo);
    drain_results();
    write_reg(CFG_BRAKE_TH, brake);
    write_reg(CFG_HARD_BRAKE_TH, hard);
    write_reg(CFG_TURN_TH, turn);
    write_reg(CFG_RELEASE_TH, rel);
    write_reg(CFG_BRAKE_HOLD, hold);
    write_reg(CFG_VOICE_TIMEOUT, tmo);
    turn_cfg    = turn;
    release_cfg = rel;
    hold_cfg    = hold;
    timeout_cfg = tmo;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // Roll aimed at the lean and release boundaries of the current settings.
  function automatic logic signed [15:0] pick_roll();
    int r;
    int sgn;
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 7))
      0: r = 0;
      1: r = sgn * (turn_cfg + int'($urandom_range(0, 2)) - 1);
      2: r = sgn * (release_cfg + int'($urandom_range(0, 2)) - 1);
      3: r = int'($urandom_range(0, 65535)) - 32768;
      default: r = int'($urandom_range(0, 36000)) - 18000;
    endcase
    return r[15:0];
  endfunction

  // Time step between evaluations; lands on hold and timeout often enough to hit
  // the exact-equality edges, now and then jumps far enough to wrap.
  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1, 2, 3: return $urandom_range(0, hold_cfg / 2 + 1);
      4: return hold_cfg;
      5: return timeout_cfg;
      6: return $urandom_range(0, timeout_cfg / 4 + 1);
      7: return 32'd1;
      8: return $urandom_range(0, hold_cfg + timeout_cfg + 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    logic [1:0]         kind;
    logic [11:0]        speed;
    logic [7:0]         voice;
    logic signed [15:0] roll;
    logic [31:0]        now;
    int                 r;
    int                 s;
    // unused fields carry junk so every bit moves
    speed = 12'($urandom);
    voice = 8'($urandom);
    roll  = 16'($urandom);
    now   = $urandom;
    r     = $urandom_range(0, 99);
    if (r < 40) begin
      kind = KIND_SPEED;
      r    = $urandom_range(0, 9);
      if (r < 5) begin
        s = $urandom_range(0, 3000);
      end else if (r < 8) begin
        s = last_speed + int'($urandom_range(0, 600)) - 300;
        if (s < 0) s = 0;
        if (s > 3000) s = 3000;
      end else if (r == 8) begin
        s = $urandom_range(3001, 4095);
      end else begin
        s = $urandom_range(0, 1) ? 3000 : 0;
      end
      speed      = 12'(s);
      last_speed = (s > 3000) ? 3000 : s;
    end else if (r < 58) begin
      kind = KIND_VOICE;
      case ($urandom_range(0, 3))
        0: voice = VOICE_LEFT;
        1: voice = VOICE_RIGHT;
        2: voice = VOICE_BRAKE;
        default: voice = 8'($urandom_range(0, 255));
      endcase
    end else if (r < 95) begin
      kind     = KIND_EVAL;
      roll     = pick_roll();
      clock_ms = clock_ms + pick_delta();
      now      = clock_ms;
    end else begin
      kind = KIND_RSVD;  // must change nothing
    end
    send_item(kind, speed, voice, roll, now);
  endtask

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) random_item();
  endtask

  // Directed opening with reset settings (brake -700, hard -8000, turn 1400,
  // release 100, hold 3000, timeout 10000). Expected states noted per step.
  task automatic directed_items();
    send_item(KIND_SPEED, 12'hFFF, 8'd0, 16'sd0, 32'd0);           // clamped to 3000
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd0, 32'd0);              // d = +30000, idle
    send_item(KIND_SPEED, 12'd3000, 8'd0, 16'sd0, 32'd0);
    send_item(KIND_SPEED, 12'd3000, 8'd0, 16'sd0, 32'd0);
    send_item(KIND_SPEED, 12'd0, 8'd0, 16'sd0, 32'd0);             // d = -30000 next
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd0, 32'd100);            // brake
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd0, 32'd1000);           // hold
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd18000, 32'd3100);       // hold ends exactly: left
    send_item(KIND_VOICE, 12'd0, VOICE_BRAKE, 16'sd0, 32'd0);
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd18000, 32'd3200);       // turn back to brake
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd0, 32'd3101);           // hard braking extends
    send_item(KIND_SPEED, 12'd0, 8'd0, 16'sd0, 32'd0);
    send_item(KIND_SPEED, 12'd0, 8'd0, 16'sd0, 32'd0);
    send_item(KIND_SPEED, 12'd0, 8'd0, 16'sd0, 32'd0);             // d = 0 from here
    send_item(KIND_VOICE, 12'd0, VOICE_RIGHT, 16'sd0, 32'd0);
    send_item(KIND_VOICE, 12'd0, 8'd0, 16'sd0, 32'd0);             // ignored codes
    send_item(KIND_VOICE, 12'd0, 8'hFF, 16'sd0, 32'd0);
    send_item(KIND_EVAL, 12'd0, 8'd0, -16'sd18000, 32'd6101);      // hold ends exactly: right
    send_item(KIND_EVAL, 12'd0, 8'd0, -16'sd18000, 32'd6200);      // lean locks
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd0, 32'd6300);           // released: idle
    send_item(KIND_VOICE, 12'd0, VOICE_LEFT, 16'sd0, 32'd0);
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd0, 32'd7000);           // voice left
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd500, 32'd17000);        // timeout exactly: stays
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd500, 32'd17001);        // timed out: idle
    send_item(KIND_RSVD, 12'hFFF, 8'hFF, -16'sd1, 32'hFFFF_FFFF);  // reserved kind
    send_item(KIND_VOICE, 12'd0, VOICE_BRAKE, 16'sd0, 32'd0);
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd0, 32'hFFFF_FF00);      // voice brake
    send_item(KIND_EVAL, 12'd0, 8'd0, -16'sd32768, 32'h0000_0100); // wrapped, still holding
    send_item(KIND_EVAL, 12'd0, 8'd0, 16'sd0, 32'h0000_0C00);      // past hold: idle
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_SPEED;
    speed_sample_i = '0;
    voice_code_i   = '0;
    roll_angle_i   = '0;
    now_ms_i       = '0;
    last_speed     = 0;
    clock_ms       = $urandom;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_items();

    // reset settings, no idling
    drain_results();
    set_idling(0);
    random_run(150);

    // short hold and timeout so the equality edges come up often; sender idles
    load_settings(-700, -8000, 1400, 100, 8, 20);
    set_idling(1);
    random_run(150);

    // low extremes; receiver stalls
    load_settings(-30000, 30000, 0, 18000, 0, 0);
    set_idling(2);
    random_run(150);

    // high extremes; both sides idle
    load_settings(30000, -30000, 18000, 0, 65535, 65535);
    set_idling(3);
    random_run(150);

    // random settings; each chunk starts from a fully drained pipe
    for (int chunk = 0; chunk < 5; chunk++) begin
      int turn;
      turn = $urandom_range(200, 6000);
      load_settings(-int'($urandom_range(0, 3000)), -int'($urandom_range(2000, 15000)),
                    turn, $urandom_range(0, turn), $urandom_range(1, 60),
                    $urandom_range(1, 120));
      set_idling(chunk % 4);
      random_run(50);
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> brake_turn_signal_controller.f
+incdir+src
src/bts_pkg.sv
src/bts_cfg_regs.sv
src/bts_core.sv
src/brake_turn_signal_controller.sv
src/bts_checker.sv
test/bts_signal_checker.sv
test/testbench.sv
